>>> rtl/pbrm_pkg.sv
package pbrm_pkg;

  // Bitmap geometry
  localparam int unsigned BITMAP_BYTES = 131072;
  localparam int unsigned PAGE_BYTES   = 4096;
  localparam int unsigned PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int unsigned MEM_AW       = $clog2(BITMAP_BYTES);
  localparam int unsigned PAGE_IDX_W   = MEM_AW + 3;       // page number inside the bitmap
  localparam int unsigned PG_W         = PAGE_IDX_W + 1;   // also holds the page limit

  // Field widths
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned TYPE_W      = 32;
  localparam int unsigned BYTE_IDX_W  = 17;
  localparam int unsigned COUNT_W     = 21;
  localparam int unsigned KADDR_W     = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned FULL_PG_W   = ADDR_W + 1 - PAGE_SHIFT;  // page of a 65-bit end address
  localparam int unsigned KS_PG_W     = KADDR_W - PAGE_SHIFT + 1;
  localparam int unsigned KE_PG_W     = KADDR_W - PAGE_SHIFT;

  // First page number past the bitmap
  localparam logic [FULL_PG_W-1:0] LIMIT_PG = FULL_PG_W'(64'(BITMAP_BYTES) * 64'd8);

  // Operation codes
  localparam logic OP_REGION = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Memory map type that marks usable memory
  localparam logic [TYPE_W-1:0] TYPE_AVAIL = TYPE_W'(1);

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_KSTART = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KEND   = CFG_IDX_W'(1);
  localparam logic [KADDR_W-1:0]   KSTART_RST = 32'hFFFF_FFFF;
  localparam logic [KADDR_W-1:0]   KEND_RST   = 32'h0000_0000;

  // Kernel range expressed in pages: excluded iff start_pg <= p <= end_pg
  typedef struct packed {
    logic [KS_PG_W-1:0] start_pg;
    logic [KE_PG_W-1:0] end_pg;
  } kpg_t;

  // Classified command from front to back
  typedef struct packed {
    logic                  op;
    logic                  run;       // region has pages to walk inside the bitmap
    logic [PG_W-1:0]       first_pg;
    logic [PG_W-1:0]       top_pg;    // one past the last page to walk
    logic                  beyond;
    logic                  last;
    logic [BYTE_IDX_W-1:0] byte_idx;
  } cmd_t;

  // Lowest page whose address is at or above addr
  function automatic logic [KS_PG_W-1:0] ceil_page(input logic [KADDR_W-1:0] addr);
    logic [KS_PG_W-1:0] pg;
    pg = KS_PG_W'(addr[KADDR_W-1:PAGE_SHIFT]) + KS_PG_W'(|addr[PAGE_SHIFT-1:0]);
    return pg;
  endfunction

  // Page holding addr
  function automatic logic [KE_PG_W-1:0] floor_page(input logic [KADDR_W-1:0] addr);
    return addr[KADDR_W-1:PAGE_SHIFT];
  endfunction

endpackage

>>> rtl/page_bitmap_region_marker_unit.sv
// Page-frame bitmap builder, one bit per physical page (1 = available).
// Input queue: drive a beat with push while full is low. operation 0 applies
// one memory-map region; only type-1 regions set bits, outside the kernel
// range written through cfg (index 0 kernel start, index 1 kernel end, both
// inclusive byte addresses). operation 1 reads one bitmap byte.
// Result queue: every input beat gives one result beat, in order; it sits on
// the result ports while empty is low and leaves on pop.
// Path: a beat passes the input stage, the command queue and the back end,
// whose result register holds the result beat. A region walks each bitmap
// byte its pages touch in a read-modify-write loop (mask, then merge) on the
// bitmap memory; reads and beats with no pages inside the bitmap skip it.
// The back end works on one beat at a time and takes the next from the
// command queue only once its result has gone to the result register.
// Reset: the bitmap is cleared by a pass over its 131072 bytes, one byte a cycle;
// up to three beats are taken meanwhile and then full rises. Configuration
// writes are taken at any time but belong to idle periods.
// Stall: while a result waits the back end finishes one more beat and holds
// it; the front keeps taking beats until its two-entry command queue and
// input stage are full, five beats in all, and then raises full.
module page_bitmap_region_marker_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              operation_i,
  input  logic [pbrm_pkg::ADDR_W-1:0]       region_base_i,
  input  logic [pbrm_pkg::ADDR_W-1:0]       region_length_i,
  input  logic [pbrm_pkg::TYPE_W-1:0]       region_type_i,
  input  logic [pbrm_pkg::BYTE_IDX_W-1:0]   byte_index_i,
  input  logic                              last_region_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [7:0]                        read_byte_o,
  output logic [pbrm_pkg::COUNT_W-1:0]      pages_marked_o,
  output logic                              beyond_bitmap_o,
  output logic                              map_complete_o,
  input  logic                              cfg_we_i,
  input  logic [pbrm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pbrm_pkg::KADDR_W-1:0]      cfg_wdata_i
);
  import pbrm_pkg::*;

  kpg_t  kpg_q;
  cmd_t  front_cmd, fifo_cmd;
  logic  cmd_push, cmd_full, cmd_pop, cmd_empty;

  // Kernel range kept in page units
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kpg_q.start_pg <= ceil_page(KSTART_RST);
      kpg_q.end_pg   <= floor_page(KEND_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KSTART: kpg_q.start_pg <= ceil_page(cfg_wdata_i);
        CFG_KEND:   kpg_q.end_pg   <= floor_page(cfg_wdata_i);
        default: begin
        end
      endcase
    end
  end

  pbrm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .operation_i     (operation_i),
    .region_base_i   (region_base_i),
    .region_length_i (region_length_i),
    .region_type_i   (region_type_i),
    .byte_index_i    (byte_index_i),
    .last_region_i   (last_region_i),
    .kpg_i           (kpg_q),
    .cmd_o           (front_cmd),
    .cmd_push_o      (cmd_push),
    .cmd_full_i      (cmd_full)
  );

  pbrm_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .cmd_o   (fifo_cmd),
    .empty_o (cmd_empty)
  );

  pbrm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (fifo_cmd),
    .cmd_empty_i     (cmd_empty),
    .cmd_pop_o       (cmd_pop),
    .kpg_i           (kpg_q),
    .empty_o         (empty),
    .pop_i           (pop),
    .read_byte_o     (read_byte_o),
    .pages_marked_o  (pages_marked_o),
    .beyond_bitmap_o (beyond_bitmap_o),
    .map_complete_o  (map_complete_o)
  );

endmodule

>>> rtl/pbrm_front.sv
module pbrm_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic                              operation_i,
  input  logic [pbrm_pkg::ADDR_W-1:0]       region_base_i,
  input  logic [pbrm_pkg::ADDR_W-1:0]       region_length_i,
  input  logic [pbrm_pkg::TYPE_W-1:0]       region_type_i,
  input  logic [pbrm_pkg::BYTE_IDX_W-1:0]   byte_index_i,
  input  logic                              last_region_i,
  input  pbrm_pkg::kpg_t                    kpg_i,
  output pbrm_pkg::cmd_t                    cmd_o,
  output logic                              cmd_push_o,
  input  logic                              cmd_full_i
);
  import pbrm_pkg::*;

  logic                   s1_valid_q;
  logic                   op_q, avail_q, last_q;
  logic [FULL_PG_W-1:0]   first_q, stop_q;
  logic [BYTE_IDX_W-1:0]  bidx_q;
  logic                   accept;
  logic [ADDR_W:0]        end_sum;

  logic                   nonempty, over, excl_lo, excl_hi, region_go;
  logic [FULL_PG_W-1:0]   bl, ks_ext, ke_ext;

  // Stage one holds one beat until the queue takes it
  assign full_o     = s1_valid_q && cmd_full_i;
  assign accept     = push_i && !full_o;
  assign cmd_push_o = s1_valid_q && !cmd_full_i;

  // 65-bit end address so base + length cannot wrap
  assign end_sum = {1'b0, region_base_i} + {1'b0, region_length_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (cmd_push_o) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Round start up and end down to page boundaries
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= operation_i;
      avail_q <= (region_type_i == TYPE_AVAIL);
      last_q  <= last_region_i;
      bidx_q  <= byte_index_i;
      first_q <= FULL_PG_W'(region_base_i[ADDR_W-1:PAGE_SHIFT])
                 + FULL_PG_W'(|region_base_i[PAGE_SHIFT-1:0]);
      stop_q  <= end_sum[ADDR_W:PAGE_SHIFT];
    end
  end

  // Classify: clip to the bitmap and check the overflow ends against the kernel range
  always_comb begin
    ks_ext    = FULL_PG_W'(kpg_i.start_pg);
    ke_ext    = FULL_PG_W'(kpg_i.end_pg);
    region_go = (op_q == OP_REGION) && avail_q;
    nonempty  = first_q < stop_q;
    over      = stop_q > LIMIT_PG;
    bl        = (first_q > LIMIT_PG) ? first_q : LIMIT_PG;
    excl_lo   = (bl >= ks_ext) && (bl <= ke_ext);
    // last page (stop - 1) inside the kernel range
    excl_hi   = (stop_q > ks_ext) && (stop_q <= ke_ext + FULL_PG_W'(1));

    cmd_o.op       = op_q;
    cmd_o.run      = region_go && nonempty && (first_q < LIMIT_PG);
    cmd_o.first_pg = first_q[PG_W-1:0];
    cmd_o.top_pg   = over ? LIMIT_PG[PG_W-1:0] : stop_q[PG_W-1:0];
    cmd_o.beyond   = region_go && nonempty && over && (!excl_lo || !excl_hi);
    cmd_o.last     = last_q;
    cmd_o.byte_idx = bidx_q;
  end

endmodule

>>> rtl/pbrm_cmd_fifo.sv
module pbrm_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pbrm_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output pbrm_pkg::cmd_t  cmd_o,
  output logic            empty_o
);
  import pbrm_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  cmd_t             slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slot_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> rtl/pbrm_back.sv
module pbrm_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pbrm_pkg::cmd_t                    cmd_i,
  input  logic                              cmd_empty_i,
  output logic                              cmd_pop_o,
  input  pbrm_pkg::kpg_t                    kpg_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic [7:0]                        read_byte_o,
  output logic [pbrm_pkg::COUNT_W-1:0]      pages_marked_o,
  output logic                              beyond_bitmap_o,
  output logic                              map_complete_o
);
  import pbrm_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MASK  = 3'd2;
  localparam logic [2:0] ST_MERGE = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam int unsigned CMP_W = (PG_W > KS_PG_W) ? PG_W : KS_PG_W;

  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  logic [2:0]          state_q, state_d;
  logic [MEM_AW-1:0]   clr_q;
  cmd_t                cmd_q;
  logic [MEM_AW-1:0]   cur_q, end_q;
  logic [COUNT_W-1:0]  count_q;
  logic [7:0]          mask_q, mask_d;
  logic                map_done_q;

  logic [7:0]          mem [BITMAP_BYTES];
  logic [7:0]          rdata_q;
  logic                mem_we, mem_re;
  logic [MEM_AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]          mem_wdata;

  logic                out_valid_q;
  logic                out_free;
  logic [PG_W-1:0]     top_m1;

  assign out_free  = !out_valid_q || pop_i;
  assign empty_o   = !out_valid_q;
  assign cmd_pop_o = (state_q == ST_IDLE) && !cmd_empty_i;
  assign top_m1    = cmd_i.top_pg - PG_W'(1);

  // Lane masks for the eight pages of the current byte
  always_comb begin
    logic [CMP_W-1:0] pg;
    logic             in_rng, excl;
    mask_d = '0;
    for (int i = 0; i < 8; i++) begin
      pg     = CMP_W'({cur_q, 3'(i)});
      in_rng = (pg >= CMP_W'(cmd_q.first_pg)) && (pg < CMP_W'(cmd_q.top_pg));
      excl   = (pg >= CMP_W'(kpg_i.start_pg)) && (pg <= CMP_W'(kpg_i.end_pg));
      mask_d[i] = in_rng && !excl;
    end
  end

  // Memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_q;
    mem_wdata = rdata_q | mask_q;
    mem_re    = 1'b0;
    mem_raddr = cur_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_re    = cmd_pop_o && (cmd_i.op == OP_READ);
        mem_raddr = cmd_i.byte_idx[MEM_AW-1:0];
      end
      ST_MASK: begin
        mem_re = 1'b1;
      end
      ST_MERGE: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == MEM_AW'(BITMAP_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_pop_o) begin
          state_d = cmd_i.run ? ST_MASK : ST_OUT;
        end
      end
      ST_MASK:  state_d = ST_MERGE;
      ST_MERGE: state_d = (cur_q == end_q) ? ST_OUT : ST_MASK;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      map_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + MEM_AW'(1);
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
        if (cmd_q.op == OP_REGION && cmd_q.last) begin
          map_done_q <= 1'b1;
        end
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Walk state and result beat
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o) begin
          cmd_q   <= cmd_i;
          cur_q   <= cmd_i.first_pg[PAGE_IDX_W-1:3];
          end_q   <= top_m1[PAGE_IDX_W-1:3];
          count_q <= '0;
        end
      end
      ST_MASK: begin
        mask_q <= mask_d;
      end
      ST_MERGE: begin
        count_q <= count_q + COUNT_W'(popcnt8(mask_q));
        cur_q   <= cur_q + MEM_AW'(1);
      end
      ST_OUT: begin
        if (out_free) begin
          if (cmd_q.op == OP_READ) begin
            read_byte_o     <= (32'(cmd_q.byte_idx) < BITMAP_BYTES) ? rdata_q : 8'h00;
            pages_marked_o  <= '0;
            beyond_bitmap_o <= 1'b0;
            map_complete_o  <= map_done_q;
          end else begin
            read_byte_o     <= 8'h00;
            pages_marked_o  <= count_q;
            beyond_bitmap_o <= cmd_q.beyond;
            map_complete_o  <= cmd_q.last;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
